// ===== hw/rtl/bmpt_pkg.sv =====
// shared types, constants and helpers for the bus mouse packet tracker
package bmpt_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int SUM_W          = 16;
	localparam int DELTA_W        = 14;
	localparam int REG_ADDR_W     = 4;
	localparam int APB_DATA_W     = 32;

	localparam logic [7:0] LEFT_MASK  = 8'h04;
	localparam logic [7:0] RIGHT_MASK = 8'h01;

	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;
	localparam logic [6:0]  THRESH_RST = 7'd5;
	localparam logic [3:0]  GAIN_RST   = 4'd2;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2,
		REG_GAIN   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_BTN = 2'd0,
		PH_DX  = 2'd1,
		PH_DY  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [12:0] width;
		logic [12:0] height;
		logic [6:0]  thresh;
		logic [3:0]  gain;
	} cfg_t;

	// running sum plus one delta, held inside +/-32767
	function automatic logic [SUM_W-1:0] sat_add(
		input logic [SUM_W-1:0]   acc,
		input logic [DELTA_W-1:0] d
	);
		logic signed [SUM_W:0] s;
		s = $signed({acc[SUM_W-1], acc}) +
			$signed({{(SUM_W+1-DELTA_W){d[DELTA_W-1]}}, d});
		if (s > $signed(17'sd32767)) begin
			return 16'h7fff;
		end else if (s < $signed(-17'sd32767)) begin
			return 16'h8001;
		end else begin
			return s[SUM_W-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/bmpt_cfg.sv =====
// configuration registers behind the apb port
module bmpt_cfg
	import bmpt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RST;
			cfg_q.height <= HEIGHT_RST;
			cfg_q.thresh <= THRESH_RST;
			cfg_q.gain   <= GAIN_RST;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:  cfg_q.width  <= pwdata[12:0];
				REG_HEIGHT: cfg_q.height <= pwdata[12:0];
				REG_THRESH: cfg_q.thresh <= pwdata[6:0];
				REG_GAIN:   cfg_q.gain   <= pwdata[3:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = {19'd0, cfg_q.width};
			REG_HEIGHT: prdata = {19'd0, cfg_q.height};
			REG_THRESH: prdata = {25'd0, cfg_q.thresh};
			REG_GAIN:   prdata = {28'd0, cfg_q.gain};
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/bmpt_core.sv =====
// packet assembly, motion accumulation and cursor update for one byte a cycle while step is high
module bmpt_core
	import bmpt_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  batch_end,
	output logic                  emit,
	output logic [COORD_BITS-1:0] cursor_x,
	output logic [COORD_BITS-1:0] cursor_y,
	output logic                  left_pressed,
	output logic                  right_pressed
);

	localparam int VW = ((COORD_BITS > SUM_W) ? COORD_BITS : SUM_W) + 2;

	phase_t                phase_q, phase_nxt;
	logic [7:0]            hold0_q, hold1_q;
	logic [SUM_W-1:0]      sum_dx_q, sum_dy_q;
	logic                  pending_q;
	logic [1:0]            last_btn_q;
	logic                  known_q;
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q;

	logic                  pkt, pkt_emit, bend_emit, flush;
	logic [1:0]            btn, out_btn;
	logic signed [8:0]     dx9, dy9, ax9, ay9;
	logic                  accel;
	logic signed [DELTA_W-1:0] gx, gy, dxs, dys;
	logic [SUM_W-1:0]      sx, sy, ux, uy;
	logic [VW-1:0]         hi_x, hi_y;
	logic signed [VW-1:0]  vx, vy;

	// clamp to [0, hi]
	function automatic logic [COORD_BITS-1:0] clamp(
		input logic signed [VW-1:0] v,
		input logic [VW-1:0]        hi
	);
		if (v < 0) begin
			return '0;
		end else if (v > $signed(hi)) begin
			return hi[COORD_BITS-1:0];
		end else begin
			return v[COORD_BITS-1:0];
		end
	endfunction

	// screen size zero acts as one, limit also capped at the coordinate range
	function automatic logic [VW-1:0] limit(input logic [12:0] size);
		logic [VW-1:0] m1;
		logic [VW-1:0] cmax;
		m1   = (size == 13'd0) ? '0 : VW'(size - 13'd1);
		cmax = VW'({COORD_BITS{1'b1}});
		return (m1 < cmax) ? m1 : cmax;
	endfunction

	// phase sequencing
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_BTN:  phase_nxt = PH_DX;
			PH_DX:   phase_nxt = PH_DY;
			PH_DY:   phase_nxt = PH_BTN;
			default: phase_nxt = PH_DX;
		endcase
	end

	always_comb begin
		pkt = step && (phase_q == PH_DY);
	end

	// delta decode and acceleration
	assign dx9   = $signed({hold1_q[7], hold1_q});
	assign dy9   = $signed({data_byte[7], data_byte});
	assign ax9   = dx9[8] ? -dx9 : dx9;
	assign ay9   = dy9[8] ? -dy9 : dy9;
	assign accel = (ax9 > $signed({2'b00, cfg.thresh})) ||
		(ay9 > $signed({2'b00, cfg.thresh}));
	assign gx    = dx9 * $signed({1'b0, cfg.gain});
	assign gy    = dy9 * $signed({1'b0, cfg.gain});
	assign dxs   = accel ? gx : DELTA_W'(dx9);
	assign dys   = accel ? gy : DELTA_W'(dy9);
	assign sx    = sat_add(sum_dx_q, dxs);
	assign sy    = sat_add(sum_dy_q, dys);

	assign btn = {(hold0_q & LEFT_MASK) != 8'd0, (hold0_q & RIGHT_MASK) != 8'd0};

	assign pkt_emit  = pkt && (!known_q || (btn != last_btn_q));
	assign bend_emit = step && batch_end && !pkt_emit && (pkt || pending_q);
	assign emit      = pkt_emit || bend_emit;
	assign flush     = emit || (step && batch_end);
	assign out_btn   = pkt_emit ? btn : last_btn_q;

	// motion used for this update includes the packet finishing now
	assign ux = pkt ? sx : sum_dx_q;
	assign uy = pkt ? sy : sum_dy_q;

	assign hi_x = limit(cfg.width);
	assign hi_y = limit(cfg.height);
	assign vx = $signed({{(VW-COORD_BITS){1'b0}}, pos_x_q}) +
		$signed({{(VW-SUM_W){ux[SUM_W-1]}}, ux});
	assign vy = $signed({{(VW-COORD_BITS){1'b0}}, pos_y_q}) -
		$signed({{(VW-SUM_W){uy[SUM_W-1]}}, uy});

	assign cursor_x      = clamp(vx, hi_x);
	assign cursor_y      = clamp(vy, hi_y);
	assign left_pressed  = out_btn[1];
	assign right_pressed = out_btn[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_BTN;
			sum_dx_q   <= '0;
			sum_dy_q   <= '0;
			pending_q  <= 1'b0;
			last_btn_q <= '0;
			known_q    <= 1'b0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
		end else if (step) begin
			phase_q <= phase_nxt;
			if (flush) begin
				sum_dx_q  <= '0;
				sum_dy_q  <= '0;
				pending_q <= 1'b0;
			end else if (pkt) begin
				sum_dx_q  <= sx;
				sum_dy_q  <= sy;
				pending_q <= 1'b1;
			end
			if (pkt) begin
				last_btn_q <= btn;
				known_q    <= 1'b1;
			end
			if (emit) begin
				pos_x_q <= cursor_x;
				pos_y_q <= cursor_y;
			end
		end
	end

	// packet bytes need no reset
	always_ff @(posedge clk) begin
		if (step && (phase_q != PH_DX) && (phase_q != PH_DY)) begin
			hold0_q <= data_byte;
		end
		if (step && (phase_q == PH_DX)) begin
			hold1_q <= data_byte;
		end
	end

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> step && ((phase_q == PH_DY) || batch_end))
		else $error("update without a packet end or batch end");

	a_known_after_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		pkt |=> known_q)
		else $error("button state not recorded after a packet");

	a_bend_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && batch_end |=> !pending_q && (sum_dx_q == '0) && (sum_dy_q == '0))
		else $error("motion left over after batch end");

	a_pending_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (sum_dx_q == '0) && (sum_dy_q == '0))
		else $error("motion accumulated without pending flag");

endmodule

// ===== hw/rtl/bus_mouse_packet_tracker.sv =====
// top level: byte stream in, cursor updates out, apb configuration
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] data_byte, tlast batch_end
// m_axis    out  m_axis_tvalid/tready       tdata cursor_x, cursor_y, left, right
// apb       in   psel/penable/pwrite/pready width, height, threshold, gain
//
// one byte per cycle while the result register is free or being taken: a request goes into the
// input register, then the core works it and, when it emits an update, loads the result register
// asynchronous active-low reset; no clearing pass is needed
// a held result that is not taken stalls the input register
module bus_mouse_packet_tracker
	import bmpt_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int OUT_BITS  = 2 * COORD_BITS + 2,
	localparam int TDATA_W   = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // data_byte
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TDATA_W-1:0]    m_axis_tdata    // cursor_x, cursor_y, left, right, zero fill
);

	cfg_t                  cfg;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  bend_s1;
	logic                  step, emit, advance;
	logic [COORD_BITS-1:0] cx, cy;
	logic                  lp, rp;
	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   out_data_q;

	bmpt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmpt_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.step          (step),
		.data_byte     (byte_s1),
		.batch_end     (bend_s1),
		.emit          (emit),
		.cursor_x      (cx),
		.cursor_y      (cy),
		.left_pressed  (lp),
		.right_pressed (rp)
	);

	// a byte moves on only when the result register is free or being taken
	assign advance       = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			bend_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_data_q <= {rp, lp, cy, cx};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_data_q);

endmodule

// ===== tb/bus_mouse_packet_tracker_test.sv =====
// testbench for the bus mouse packet tracker: byte stream in, checked cursor updates out
`timescale 1ns / 100ps

module bus_mouse_packet_tracker_test;
	import bmpt_pkg::*;

	typedef struct packed {
		logic [5:0]  pad;
		logic        right;
		logic        left;
		logic [11:0] y;
		logic [11:0] x;
	} cursor_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [REG_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;   // data_byte
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;        // cursor_x, cursor_y, left, right, zero fill

	// own copy of configuration and tracker state
	cfg_t        cfg = '{WIDTH_RST, HEIGHT_RST, THRESH_RST, GAIN_RST};
	phase_t      trk_phase = PH_BTN;
	logic [7:0]  held_btn = '0;
	logic [7:0]  held_dx = '0;
	int          acc_dx = 0;
	int          acc_dy = 0;
	bit          motion_due = 1'b0;
	logic [1:0]  last_btn = '0;
	bit          btn_seen = 1'b0;
	int          cur_x = 0;
	int          cur_y = 0;

	cursor_t     cursor_q[$];
	int          mismatches = 0;
	bit          send_idle = 1'b0;
	int          burst_left = 0;
	logic [15:0] ready_pat = 16'hffff;
	logic [3:0]  rcv_cnt = '0;

	bus_mouse_packet_tracker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int sat_sum(input int v);
		if (v > 32767) return 32767;
		if (v < -32767) return -32767;
		return v;
	endfunction

	function automatic int clamp_coord(input int v, input logic [12:0] size);
		int hi;
		hi = (size == 0) ? 0 : int'(size) - 1;
		if (hi > (1 << COORD_BITS_DEF) - 1) hi = (1 << COORD_BITS_DEF) - 1;
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic cursor_t move_cursor(input logic [1:0] btn);
		cursor_t c;
		cur_x = clamp_coord(cur_x + acc_dx, cfg.width);
		cur_y = clamp_coord(cur_y - acc_dy, cfg.height);
		c = '0;
		c.x = 12'(cur_x);
		c.y = 12'(cur_y);
		c.left = btn[1];
		c.right = btn[0];
		acc_dx = 0;
		acc_dy = 0;
		motion_due = 1'b0;
		return c;
	endfunction

	// advances the tracker by one byte; returns 1 when a cursor update follows
	function automatic bit predict_cursor(input logic [7:0] b, input logic bend,
			output cursor_t res);
		int dx, dy, ax, ay;
		logic [1:0] btn;
		bit hit;
		hit = 1'b0;
		res = '0;
		case (trk_phase)
			PH_DX: begin
				held_dx = b;
				trk_phase = PH_DY;
			end
			PH_DY: begin
				dx = $signed(held_dx);
				dy = $signed(b);
				ax = dx < 0 ? -dx : dx;
				ay = dy < 0 ? -dy : dy;
				btn = {(held_btn & LEFT_MASK) != 0, (held_btn & RIGHT_MASK) != 0};
				if (ax > int'(cfg.thresh) || ay > int'(cfg.thresh)) begin
					dx = dx * int'(cfg.gain);
					dy = dy * int'(cfg.gain);
				end
				acc_dx = sat_sum(acc_dx + dx);
				acc_dy = sat_sum(acc_dy + dy);
				motion_due = 1'b1;
				if (!btn_seen || btn != last_btn) begin
					res = move_cursor(btn);
					hit = 1'b1;
					last_btn = btn;
					btn_seen = 1'b1;
				end
				trk_phase = PH_BTN;
			end
			default: begin
				held_btn = b;
				trk_phase = PH_DX;
			end
		endcase
		if (bend) begin
			if (motion_due && !hit) begin
				res = move_cursor(last_btn);
				hit = 1'b1;
			end
			acc_dx = 0;
			acc_dy = 0;
			motion_due = 1'b0;
		end
		return hit;
	endfunction

	always @(posedge clk) begin
		rcv_cnt <= rcv_cnt + 1'b1;
		m_axis_tready <= ready_pat[rcv_cnt];
	end

	always @(posedge clk) begin
		cursor_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = cursor_t'(m_axis_tdata);
			if (cursor_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected cursor update, expected none, actual x=%0d y=%0d l=%0b r=%0b",
					$time, got.x, got.y, got.left, got.right);
			end else begin
				want = cursor_q.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.left !== want.left ||
						got.right !== want.right || got.pad !== want.pad) begin
					mismatches++;
					$display("%0t: cursor mismatch, expected x=%0d y=%0d l=%0b r=%0b pad=%0h, actual x=%0d y=%0d l=%0b r=%0b pad=%0h",
						$time, want.x, want.y, want.left, want.right, want.pad,
						got.x, got.y, got.left, got.right, got.pad);
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		cursor_t res;
		int gap;
		if (send_idle && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(1, 8);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0) burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (predict_cursor(b, last, res)) cursor_q.push_back(res);
	endtask

	task automatic wait_cursor_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (cursor_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WIDTH:  cfg.width = val[12:0];
			REG_HEIGHT: cfg.height = val[12:0];
			REG_THRESH: cfg.thresh = val[6:0];
			REG_GAIN:   cfg.gain = val[3:0];
		endcase
		@(posedge clk);
	endtask

	// only while idle: drain, let the pipeline settle, then write all registers
	task automatic reconfigure(input int w, input int h, input int thr, input int gain);
		wait_cursor_drain();
		repeat (4) @(posedge clk);
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
		write_reg(REG_THRESH, 32'(thr));
		write_reg(REG_GAIN, 32'(gain));
	endtask

	task automatic set_idling(input bit on);
		send_idle = on;
		burst_left = 0;
		ready_pat = on ? (16'($urandom) | 16'h0101) : 16'hffff;
	endtask

	function automatic logic [7:0] pick_delta(input bit big);
		int t;
		t = int'(cfg.thresh);
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: return 8'h7f;
					1: return 8'h80;
					2: return 8'h81;
					default: return 8'h00;
				endcase
			end
			1: return 8'($urandom_range(0, 2 * t) - t);
			default: begin
				if (!big) return 8'($urandom);
				// mostly one direction so the sums run into saturation
				if ($urandom_range(0, 99) < 85) return 8'($urandom_range(100, 127));
				return 8'($urandom_range(128, 160));
			end
		endcase
	endfunction

	task automatic run_packets(input int n_items, input int batch_pct, input int keep_pct,
			input bit big);
		int sent, end_at;
		logic [7:0] b0, dx, dy, prev_b0;
		sent = 0;
		prev_b0 = 8'($urandom);
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 8) begin
				// stray byte shifts the packet framing
				send_byte(8'($urandom), $urandom_range(0, 9) == 0);
				sent++;
			end else begin
				b0 = 8'($urandom);
				if ($urandom_range(0, 99) < keep_pct)
					b0 = (b0 & ~(LEFT_MASK | RIGHT_MASK)) | (prev_b0 & (LEFT_MASK | RIGHT_MASK));
				prev_b0 = b0;
				dx = pick_delta(big);
				dy = pick_delta(big);
				if ($urandom_range(0, 99) < batch_pct) end_at = 2;
				else if (batch_pct >= 10 && $urandom_range(0, 19) == 0)
					end_at = $urandom_range(0, 1);
				else end_at = 3;
				send_byte(b0, end_at == 0);
				send_byte(dx, end_at == 1);
				send_byte(dy, end_at == 2);
				sent += 3;
			end
		end
	endtask

	task automatic test_first_packet();
		// buttons released still report on the very first packet
		send_byte(8'h00, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'hfb, 1'b0);
	endtask

	task automatic test_acceleration();
		send_byte(8'h04, 1'b0);
		send_byte(8'h06, 1'b0);
		send_byte(8'h00, 1'b0);
		// same buttons, extreme deltas, flushed by the batch end
		send_byte(8'h04, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b1);
	endtask

	task automatic test_batch_end();
		// batch end inside a packet with nothing pending
		send_byte(8'h05, 1'b1);
		send_byte(8'h7f, 1'b0);
		// button change on the batch end byte reports once
		send_byte(8'h81, 1'b1);
		send_byte(8'hfb, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		// batch end on a button byte with nothing pending
		send_byte(8'h01, 1'b1);
	endtask

	task automatic test_screen_extremes();
		// zero width, oversized height, gain zero
		reconfigure(0, 8191, 127, 0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h80, 1'b1);
		reconfigure(4096, 1, 0, 15);
		send_byte(8'h04, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hff, 1'b1);
	endtask

	task automatic test_random_traffic();
		reconfigure(640, 480, 5, 2);
		set_idling(1'b0);
		run_packets(190, 30, 75, 1'b0);
		reconfigure($urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(0, 127), $urandom_range(1, 8));
		set_idling(1'b1);
		run_packets(190, 30, 75, 1'b0);
		reconfigure($urandom_range(0, 8191), $urandom_range(0, 8191),
			$urandom_range(0, 127), $urandom_range(0, 15));
		set_idling(1'b1);
		run_packets(190, 20, 60, 1'b0);
	endtask

	task automatic test_tiny_screen();
		reconfigure(1, 1, 0, 8);
		set_idling(1'b1);
		run_packets(190, 40, 50, 1'b0);
	endtask

	task automatic test_large_screen();
		reconfigure(4096, 4096, 127, 1);
		set_idling(1'b1);
		run_packets(190, 30, 75, 1'b0);
	endtask

	task automatic test_sum_saturation();
		reconfigure(8191, 0, 0, 15);
		set_idling(1'b1);
		run_packets(190, 2, 97, 1'b1);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_packet();
		test_acceleration();
		test_batch_end();
		test_screen_extremes();
		test_random_traffic();
		test_tiny_screen();
		test_large_screen();
		test_sum_saturation();
		wait_cursor_drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== bus_mouse_packet_tracker.f =====
hw/rtl/bmpt_pkg.sv
hw/rtl/bmpt_cfg.sv
hw/rtl/bmpt_core.sv
hw/rtl/bus_mouse_packet_tracker.sv
tb/bus_mouse_packet_tracker_test.sv
